FILE: hdl/hom_pkg.sv
// ----------------------------------------------------------------------------
// hom_pkg: shared types and constants of the heartbeat offline monitor
// Channel count, mode and LED codes, table entry and result layouts.
// ----------------------------------------------------------------------------
package hom_pkg;

	localparam int CHANNELS = 16;
	localparam int CH_W     = $clog2(CHANNELS);

	localparam logic [1:0] MODE_SCAN  = 2'd0;
	localparam logic [1:0] MODE_BEAT  = 2'd1;
	localparam logic [1:0] MODE_SETUP = 2'd2;
	localparam logic [1:0] MODE_QUERY = 2'd3;

	localparam logic [1:0] LED_GREEN  = 2'd0;
	localparam logic [1:0] LED_RED    = 2'd1;
	localparam logic [1:0] LED_YELLOW = 2'd2;
	localparam logic [1:0] LED_KEEP   = 2'd3;

	localparam logic [1:0] SEV_ERROR   = 2'd0;
	localparam logic [1:0] SEV_WARNING = 2'd1;

	// Per-channel settings; the entry's valid bit doubles as the enable.
	typedef struct packed {
		logic        offline;
		logic [3:0]  beeps;
		logic [15:0] timeout;
		logic [1:0]  severity;
	} hom_entry_t;

	typedef struct packed {
		logic [CH_W-1:0] raddr;
		logic            cfg_we;
		logic [CH_W-1:0] cfg_waddr;
		hom_entry_t      cfg_wdata;
		logic            ls_we;
		logic [CH_W-1:0] ls_waddr;
		logic [31:0]     ls_wdata;
	} hom_mem_req_t;

	// Result fields, first field in the highest bits.
	typedef struct packed {
		logic [3:0]  beep_out;
		logic [1:0]  led_color;
		logic [3:0]  alarm_channel;
		logic [31:0] last_seen_ms;
		logic        is_offline;
	} hom_result_t;

endpackage

FILE: hdl/heartbeat_offline_monitor_top.sv
// ----------------------------------------------------------------------------
// heartbeat_offline_monitor_top: per-channel heartbeat watchdog table
// A heartbeat or setup item goes straight to its result, a query first waits in
// QWAIT for its table read, and a scan for the walk over the table's single
// read port, one channel a cycle. One item is in work at a time: a new beat is
// taken once the last result has moved to the output register, and that register
// lets it be taken while a result waits. Reset clears every entry's valid bit,
// so all channels come up disabled, online and with a zero last-seen stamp.
// ----------------------------------------------------------------------------
module heartbeat_offline_monitor_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // channel, time_ms, severity, timeout_ms, beep_count
	input  logic [1:0]  s_tuser,  // mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // is_offline, last_seen_ms, alarm_channel, led_color, beep_out
	output logic        m_tuser   // scan_valid
);
	import hom_pkg::*;

	hom_mem_req_t req;
	logic         cfg_valid;
	hom_entry_t   rd_cfg;
	logic [31:0]  rd_last_seen;
	logic         res_valid;
	logic         res_ready;
	hom_result_t  res;
	logic         res_scan;

	logic         out_valid_q;
	hom_result_t  out_res_q;
	logic         out_scan_q;

	hom_mem u_mem (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req),
		.cfg_valid    (cfg_valid),
		.rd_cfg       (rd_cfg),
		.rd_last_seen (rd_last_seen)
	);

	hom_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.mode         (s_tuser),
		.channel      (s_tdata[3:0]),
		.time_ms      (s_tdata[35:4]),
		.severity     (s_tdata[37:36]),
		.timeout_ms   (s_tdata[53:38]),
		.beep_count   (s_tdata[57:54]),
		.req          (req),
		.cfg_valid    (cfg_valid),
		.rd_cfg       (rd_cfg),
		.rd_last_seen (rd_last_seen),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.res          (res),
		.res_scan     (res_scan)
	);

	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_res_q  <= res;
			out_scan_q <= res_scan;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'd0, out_res_q};
	assign m_tuser  = out_scan_q;

endmodule

FILE: hdl/hom_mem.sv
// ----------------------------------------------------------------------------
// hom_mem: channel table
// Settings memory and last-seen memory, each with its own write, one shared
// read address, read data in the next cycle. Entries never written read as zero.
// ----------------------------------------------------------------------------
module hom_mem (
	input  logic                clk,
	input  logic                arst_n,
	input  hom_pkg::hom_mem_req_t req,
	output logic                cfg_valid,
	output hom_pkg::hom_entry_t rd_cfg,
	output logic [31:0]         rd_last_seen
);
	import hom_pkg::*;

	hom_entry_t      cfg_mem [CHANNELS];
	logic [31:0]     ls_mem  [CHANNELS];
	logic [CHANNELS-1:0] cfg_vld_q;
	logic [CHANNELS-1:0] ls_vld_q;
	hom_entry_t      cfg_rd_q;
	logic [31:0]     ls_rd_q;
	logic            cfg_rd_vld_q;
	logic            ls_rd_vld_q;

	always_ff @(posedge clk) begin
		if (req.cfg_we) begin
			cfg_mem[req.cfg_waddr] <= req.cfg_wdata;
		end
		if (req.ls_we) begin
			ls_mem[req.ls_waddr] <= req.ls_wdata;
		end
		cfg_rd_q <= cfg_mem[req.raddr];
		ls_rd_q  <= ls_mem[req.raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_vld_q    <= '0;
			ls_vld_q     <= '0;
			cfg_rd_vld_q <= 1'b0;
			ls_rd_vld_q  <= 1'b0;
		end else begin
			if (req.cfg_we) begin
				cfg_vld_q[req.cfg_waddr] <= 1'b1;
			end
			if (req.ls_we) begin
				ls_vld_q[req.ls_waddr] <= 1'b1;
			end
			cfg_rd_vld_q <= cfg_vld_q[req.raddr];
			ls_rd_vld_q  <= ls_vld_q[req.raddr];
		end
	end

	assign cfg_valid    = cfg_rd_vld_q;
	assign rd_cfg       = cfg_rd_vld_q ? cfg_rd_q : '0;
	assign rd_last_seen = ls_rd_vld_q ? ls_rd_q : '0;

endmodule

FILE: hdl/hom_ctrl.sv
// ----------------------------------------------------------------------------
// hom_ctrl: item sequencer
// Takes one item at a time, updates the channel table and walks it on a scan,
// reading, checking and writing back the offline mark of one channel a cycle.
// ----------------------------------------------------------------------------
module hom_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           mode,
	input  logic [3:0]           channel,
	input  logic [31:0]          time_ms,
	input  logic [1:0]           severity,
	input  logic [15:0]          timeout_ms,
	input  logic [3:0]           beep_count,
	output hom_pkg::hom_mem_req_t req,
	input  logic                 cfg_valid,
	input  hom_pkg::hom_entry_t  rd_cfg,
	input  logic [31:0]          rd_last_seen,
	output logic                 res_valid,
	input  logic                 res_ready,
	output hom_pkg::hom_result_t res,
	output logic                 res_scan
);
	import hom_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_QWAIT = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0]      state_q;
	logic [31:0]     time_q;
	logic            in_range_q;
	logic [CH_W:0]   idx_q;
	logic            vld_s1;
	logic [CH_W-1:0] addr_s1;
	logic            found_q;
	logic [1:0]      best_sev_q;
	logic [CH_W-1:0] shown_q;
	logic [3:0]      beeps_q;
	hom_result_t     res_q;
	logic            scan_q;

	logic            accept;
	logic            in_range;
	logic [CH_W-1:0] ch_idx;
	logic [31:0]     silence;
	logic            off;
	logic            idx_live;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign in_range = ({28'd0, channel} < 32'(CHANNELS));
	assign ch_idx   = channel[CH_W-1:0];
	assign idx_live = (idx_q < (CH_W+1)'(CHANNELS));

	// Wrapped silence against the stored limit.
	assign silence = time_q - rd_last_seen;
	assign off     = cfg_valid && (silence > {16'd0, rd_cfg.timeout});

	always_comb begin
		req = '0;
		case (state_q)
			ST_IDLE: begin
				req.raddr     = ch_idx;
				req.ls_waddr  = ch_idx;
				req.ls_wdata  = time_ms;
				req.cfg_waddr = ch_idx;
				req.cfg_wdata = '{offline: 1'b1, beeps: beep_count,
					timeout: timeout_ms, severity: severity};
				if (accept && in_range) begin
					req.ls_we  = (mode == MODE_BEAT);
					req.cfg_we = (mode == MODE_SETUP);
				end
			end
			ST_SCAN: begin
				req.raddr     = idx_q[CH_W-1:0];
				req.cfg_waddr = addr_s1;
				req.cfg_wdata = rd_cfg;
				req.cfg_wdata.offline = off;
				// Disabled channels stay online and are left untouched.
				req.cfg_we    = vld_s1 && cfg_valid;
			end
			default: begin
				req = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			vld_s1  <= 1'b0;
			found_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					vld_s1 <= 1'b0;
					if (accept) begin
						found_q <= 1'b0;
						case (mode)
							MODE_SCAN:  state_q <= ST_SCAN;
							MODE_QUERY: state_q <= ST_QWAIT;
							default:    state_q <= ST_DONE;
						endcase
					end
				end
				ST_SCAN: begin
					vld_s1 <= idx_live;
					if (vld_s1 && off && (!found_q || rd_cfg.severity < best_sev_q)) begin
						found_q <= 1'b1;
					end
					if (!vld_s1 && !idx_live) begin
						state_q <= ST_DONE;
					end
				end
				ST_QWAIT: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				time_q     <= time_ms;
				in_range_q <= in_range;
				idx_q      <= (CH_W+1)'(1);
				res_q      <= '0;
				scan_q     <= 1'b0;
			end
			ST_SCAN: begin
				addr_s1 <= idx_q[CH_W-1:0];
				if (idx_live) begin
					idx_q <= idx_q + (CH_W+1)'(1);
				end
				if (vld_s1 && off && (!found_q || rd_cfg.severity < best_sev_q)) begin
					best_sev_q <= rd_cfg.severity;
					shown_q    <= addr_s1;
					beeps_q    <= rd_cfg.beeps;
				end
				if (!vld_s1 && !idx_live) begin
					scan_q <= 1'b1;
					if (found_q) begin
						res_q.alarm_channel <= 4'(shown_q);
						res_q.beep_out      <= beeps_q;
						case (best_sev_q)
							SEV_ERROR:   res_q.led_color <= LED_RED;
							SEV_WARNING: res_q.led_color <= LED_YELLOW;
							default:     res_q.led_color <= LED_KEEP;
						endcase
					end else begin
						res_q.alarm_channel <= 4'd0;
						res_q.beep_out      <= 4'd0;
						res_q.led_color     <= LED_GREEN;
					end
				end
			end
			ST_QWAIT: begin
				res_q.is_offline   <= in_range_q && rd_cfg.offline;
				res_q.last_seen_ms <= in_range_q ? rd_last_seen : 32'd0;
			end
			default: begin
				res_q <= res_q;
			end
		endcase
	end

	assign res_valid = (state_q == ST_DONE);
	assign res       = res_q;
	assign res_scan  = scan_q;

endmodule

FILE: tb/sv/heartbeat_offline_monitor_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heartbeat_offline_monitor_top_tb: self-checking bench for the watchdog table
// A queue of directed and random beats feeds a stream driver; a table model
// in the bench predicts each result, and the monitor compares every output
// beat field by field, under random back-pressure and one long hold-off.
// ----------------------------------------------------------------------------
module heartbeat_offline_monitor_top_tb;
	import hom_pkg::*;

	localparam int STALL_LIMIT   = 2000;
	localparam int HOLD_CYCLES   = 300;
	localparam int HOLD_AT_BEAT  = 400;
	localparam int CALM_FROM     = 100;
	localparam int CALM_TO       = 220;
	localparam int RANDOM_ITEMS  = 630;
	localparam int DRAIN_CYCLES  = 40;

	typedef struct {
		logic [1:0]  mode;
		logic [3:0]  ch;
		logic [31:0] t;
		logic [1:0]  sev;
		logic [15:0] tmo;
		logic [3:0]  beeps;
	} hb_item_t;

	typedef struct {
		hom_result_t fields;
		logic        scan_valid;
	} hb_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;
	logic        m_tuser;

	heartbeat_offline_monitor_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// Bench copy of the channel table.
	logic        tbl_en    [CHANNELS] = '{default: '0};
	logic [1:0]  tbl_sev   [CHANNELS] = '{default: '0};
	logic [15:0] tbl_tmo   [CHANNELS] = '{default: '0};
	logic [3:0]  tbl_beeps [CHANNELS] = '{default: '0};
	logic [31:0] tbl_last  [CHANNELS] = '{default: '0};
	logic        tbl_off   [CHANNELS] = '{default: '0};

	hb_item_t   pending_items[$];
	hb_result_t exp_results[$];
	hb_item_t   cur_item;
	int         total_items = 0;
	int         beats_in = 0;
	int         beats_out = 0;
	int         mismatches = 0;
	int         quiet_cycles = 0;
	int         hold_left = 0;
	logic       hold_done = 1'b0;

	function automatic hb_result_t hb_table_step(hb_item_t it);
		hb_result_t r;
		logic [31:0] silence;
		int best_sev;
		int shown;
		logic in_range;
		r.fields = '0;
		r.scan_valid = 1'b0;
		in_range = int'(it.ch) < CHANNELS;
		case (it.mode)
			MODE_SCAN: begin
				best_sev = 256;
				shown = 0;
				for (int i = 1; i < CHANNELS; i++) begin
					silence = it.t - tbl_last[i];
					if (tbl_en[i] && silence > {16'd0, tbl_tmo[i]}) begin
						tbl_off[i] = 1'b1;
						if (int'(tbl_sev[i]) < best_sev) begin
							best_sev = int'(tbl_sev[i]);
							shown = i;
						end
					end else begin
						tbl_off[i] = 1'b0;
					end
				end
				if (shown != 0) begin
					r.fields.alarm_channel = shown[3:0];
					r.fields.beep_out = tbl_beeps[shown];
					if (tbl_sev[shown] == SEV_ERROR)
						r.fields.led_color = LED_RED;
					else if (tbl_sev[shown] == SEV_WARNING)
						r.fields.led_color = LED_YELLOW;
					else
						r.fields.led_color = LED_KEEP;
				end else begin
					r.fields.led_color = LED_GREEN;
				end
				r.scan_valid = 1'b1;
			end
			MODE_BEAT: begin
				if (in_range)
					tbl_last[it.ch] = it.t;
			end
			MODE_SETUP: begin
				if (in_range) begin
					tbl_en[it.ch]    = 1'b1;
					tbl_sev[it.ch]   = it.sev;
					tbl_tmo[it.ch]   = it.tmo;
					tbl_beeps[it.ch] = it.beeps;
					tbl_off[it.ch]   = 1'b1;
				end
			end
			default: begin
				if (in_range) begin
					r.fields.is_offline   = tbl_off[it.ch];
					r.fields.last_seen_ms = tbl_last[it.ch];
				end
			end
		endcase
		return r;
	endfunction

	task automatic queue_item(logic [1:0] mode, logic [3:0] ch, logic [31:0] t,
			logic [1:0] sev, logic [15:0] tmo, logic [3:0] beeps);
		hb_item_t it;
		it.mode = mode;
		it.ch = ch;
		it.t = t;
		it.sev = sev;
		it.tmo = tmo;
		it.beeps = beeps;
		pending_items.push_back(it);
		total_items++;
	endtask

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Driver: offers the next queued beat, predicting each one as it is taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= '0;
		end else begin : drive
			logic gap;
			if (s_tvalid && s_tready) begin
				exp_results.push_back(hb_table_step(cur_item));
				beats_in <= beats_in + 1;
			end
			gap = ($urandom_range(0, 99) < 17) && !(beats_in >= CALM_FROM && beats_in < CALM_TO);
			if (!s_tvalid || s_tready) begin
				if (pending_items.size() != 0 && !gap) begin
					cur_item = pending_items.pop_front();
					s_tdata  <= {6'd0, cur_item.beeps, cur_item.tmo, cur_item.sev,
						cur_item.t, cur_item.ch};
					s_tuser  <= cur_item.mode;
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// One long hold-off on the output so that the block backs up and stalls.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && beats_in >= HOLD_AT_BEAT) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Monitor: checks each output beat against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin : watch
			hom_result_t got;
			hb_result_t want;
			logic gap;
			if (m_tvalid && m_tready) begin
				got = hom_result_t'(m_tdata[$bits(hom_result_t)-1:0]);
				beats_out <= beats_out + 1;
				if (exp_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Unexpected result beat: data %h user %b", m_tdata, m_tuser);
				end else begin
					want = exp_results.pop_front();
					if (got.is_offline !== want.fields.is_offline
							|| got.last_seen_ms !== want.fields.last_seen_ms
							|| got.alarm_channel !== want.fields.alarm_channel
							|| got.led_color !== want.fields.led_color
							|| got.beep_out !== want.fields.beep_out
							|| m_tuser !== want.scan_valid
							|| m_tdata[47:$bits(hom_result_t)] !== '0) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("Mismatch on result %0d:", beats_out);
							$display("  expected off %b seen %h alarm %0d led %0d beep %0d scan %b",
								want.fields.is_offline, want.fields.last_seen_ms,
								want.fields.alarm_channel, want.fields.led_color,
								want.fields.beep_out, want.scan_valid);
							$display("  actual   off %b seen %h alarm %0d led %0d beep %0d scan %b",
								got.is_offline, got.last_seen_ms, got.alarm_channel,
								got.led_color, got.beep_out, m_tuser);
						end
					end
				end
			end
			gap = ($urandom_range(0, 99) < 17) && !(beats_out >= CALM_FROM && beats_out < CALM_TO);
			m_tready <= (hold_left == 0) && !gap;
		end
	end

	// Watchdog on cycles in which neither side moves a beat.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Timeout: no beat moved for %0d cycles", quiet_cycles);
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin : stimulus
		logic [31:0] now;
		logic [1:0]  mode;
		logic [15:0] tmo;
		int pick;
		arst_n = 1'b0;

		// Directed part: fresh table, timeout boundary, colours, ties, wrap, channel zero.
		queue_item(MODE_QUERY, 4'd5, $urandom, 2'($urandom), 16'($urandom), 4'($urandom));
		queue_item(MODE_SCAN,  4'd0, 32'd0, 2'd0, 16'd0, 4'd0);
		queue_item(MODE_SETUP, 4'd3, 32'd0, SEV_ERROR, 16'd10, 4'd15);
		queue_item(MODE_QUERY, 4'd3, 32'd0, 2'd3, 16'hFFFF, 4'd15);
		queue_item(MODE_BEAT,  4'd3, 32'd100, 2'd0, 16'd0, 4'd0);
		queue_item(MODE_SCAN,  4'd0, 32'd110, 2'd0, 16'd0, 4'd0);
		queue_item(MODE_SCAN,  4'd0, 32'd111, 2'd0, 16'd0, 4'd0);
		queue_item(MODE_SETUP, 4'd7, 32'd0, SEV_WARNING, 16'd0, 4'd5);
		queue_item(MODE_SETUP, 4'd9, 32'd0, SEV_WARNING, 16'hFFFF, 4'd0);
		queue_item(MODE_BEAT,  4'd3, 32'd200, 2'd0, 16'd0, 4'd0);
		queue_item(MODE_SCAN,  4'd0, 32'd200, 2'd0, 16'd0, 4'd0);
		queue_item(MODE_SETUP, 4'd12, 32'd0, 2'd3, 16'd0, 4'd9);
		queue_item(MODE_SETUP, 4'd13, 32'd0, 2'd2, 16'd0, 4'd4);
		queue_item(MODE_SETUP, 4'd15, 32'd0, 2'd2, 16'd0, 4'd1);
		queue_item(MODE_BEAT,  4'd7, 32'd300, 2'd0, 16'd0, 4'd0);
		queue_item(MODE_BEAT,  4'd3, 32'd300, 2'd0, 16'd0, 4'd0);
		queue_item(MODE_SCAN,  4'd0, 32'd300, 2'd0, 16'd0, 4'd0);
		queue_item(MODE_BEAT,  4'd9, 32'hFFFF_FFF0, 2'd0, 16'd0, 4'd0);
		queue_item(MODE_SCAN,  4'd0, 32'h0000_000F, 2'd0, 16'd0, 4'd0);
		queue_item(MODE_SETUP, 4'd0, 32'd0, SEV_ERROR, 16'd0, 4'd15);
		queue_item(MODE_BEAT,  4'd0, 32'hFFFF_FFFF, 2'd0, 16'd0, 4'd0);
		queue_item(MODE_QUERY, 4'd0, 32'd0, 2'd0, 16'd0, 4'd0);
		queue_item(MODE_SCAN,  4'd0, 32'hFFFF_FFFF, 2'd3, 16'hFFFF, 4'd15);
		queue_item(MODE_QUERY, 4'd0, 32'd0, 2'd0, 16'd0, 4'd0);
		queue_item(MODE_BEAT,  4'd15, 32'hFFFF_FFFF, 2'd0, 16'd0, 4'd0);
		queue_item(MODE_QUERY, 4'd15, 32'hFFFF_FFFF, 2'd0, 16'd0, 4'd0);

		// Random part: a running clock with heartbeats, set-ups, scans and queries,
		// now and then a jump in time or a wholly random beat.
		now = $urandom;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			now = now + $urandom_range(0, 40);
			if ($urandom_range(0, 19) == 0)
				now = now + $urandom;
			pick = $urandom_range(0, 99);
			if (pick < 4) begin
				queue_item(2'($urandom), 4'($urandom), $urandom, 2'($urandom),
					16'($urandom), 4'($urandom));
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 28)
					mode = MODE_SCAN;
				else if (pick < 60)
					mode = MODE_BEAT;
				else if (pick < 72)
					mode = MODE_SETUP;
				else
					mode = MODE_QUERY;
				pick = $urandom_range(0, 99);
				if (mode != MODE_SETUP)
					tmo = 16'($urandom);
				else if (pick < 70)
					tmo = 16'($urandom_range(0, 1500));
				else if (pick < 85)
					tmo = 16'd0;
				else
					tmo = 16'($urandom);
				queue_item(mode, 4'($urandom), now, 2'($urandom), tmo, 4'($urandom));
			end
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (beats_in != total_items)
			@(posedge clk);
		while (exp_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
